/* rtl/bmnp_pkg.sv */
package bmnp_pkg;

   // Default width of the length and period counters.
   localparam int COUNT_WIDTH_DEF = 32;

   // Field widths of the channels.
   localparam int OP_W    = 2;
   localparam int PITCH_W = 13;
   localparam int NDIV_W  = 8;
   localparam int TEMPO_W = 10;
   localparam int PHASE_W = 3;

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PAUSE = 2'd2;
   localparam logic [OP_W-1:0] OP_ABORT = 2'd3;

   // Phase codes as reported on the result channel.
   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_TONE   = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_GAP    = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_REST   = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_PAUSED = 3'd4;

   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;

   // Widths of the intermediate values of the note set-up.
   localparam int MS_W       = 18;
   localparam int PERIOD_W   = 20;
   localparam int HALF_W     = 19;
   localparam int MULT_W     = 11;
   localparam int LEN_PROD_W = MS_W + MULT_W;
   // Widest divisor is ten times the longest period.
   localparam int DSR_W      = 24;

   localparam logic [MS_W-1:0]     WHOLE_BASE_MS   = 18'd240000;
   localparam logic [PERIOD_W-1:0] US_PER_S        = 20'd1000000;
   localparam logic [MULT_W-1:0]   LEN_MULT_PLAIN  = 11'd1000;
   localparam logic [MULT_W-1:0]   LEN_MULT_DOTTED = 11'd1500;
   localparam logic [DSR_W-1:0]    GAP_DIVISOR     = 24'd10;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/bmnp_if.sv */
// Note request channel.
interface bmnp_req_if;
   import bmnp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic [PITCH_W-1:0]        pitch_hz;
   logic signed [NDIV_W-1:0]  note_divider;

   modport source (output valid, output operation, output pitch_hz, output note_divider,
                   input ready);
   modport sink   (input valid, input operation, input pitch_hz, input note_divider,
                   output ready);
endinterface

// Player status channel, one transfer per request.
interface bmnp_rsp_if;
   import bmnp_pkg::*;
   logic               valid;
   logic               ready;
   logic               buzzer_level;
   logic               indicator_led_n;
   logic [PHASE_W-1:0] player_phase;
   logic               ready_for_note;

   modport source (output valid, output buzzer_level, output indicator_led_n,
                   output player_phase, output ready_for_note, input ready);
   modport sink   (input valid, input buzzer_level, input indicator_led_n,
                   input player_phase, input ready_for_note, output ready);
endinterface

// Tempo register write channel.
interface bmnp_csr_if;
   import bmnp_pkg::*;
   logic               valid;
   logic               ready;
   logic [TEMPO_W-1:0] tempo_bpm;

   modport source (output valid, output tempo_bpm, input ready);
   modport sink   (input valid, input tempo_bpm, output ready);
endinterface

/* rtl/bmnp_serial_div.sv */
module bmnp_serial_div #(
   parameter int DVD_W = bmnp_pkg::COUNT_WIDTH_DEF + 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          div_start,
   input  logic [$clog2(DVD_W+1)-1:0]    nbits,
   input  logic [DVD_W-1:0]              dividend,
   input  logic [bmnp_pkg::DSR_W-1:0]    divisor,
   output bmnp_pkg::div_stat_type        stat,
   output logic [DVD_W-1:0]              quotient
);
   import bmnp_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W:0]   rem_shift;
   logic [DSR_W:0]   rem_diff;
   logic             fits;

   // One restoring step: bring down the next dividend bit and try the subtraction.
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign fits      = (rem_shift >= {1'b0, dsr_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (div_start) begin
         // The dividend arrives left-aligned, so only nbits steps are needed.
         cnt_in  = nbits;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quot_in = {quot_ff[DVD_W-2:0], fits};
         rem_in  = fits ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
      end
   end

   // Control state is reset; the datapath registers load on start.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

   // The done pulse follows the last step.
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == CNT_W'(1))
      else $error("divider done without a final step");

   // A new division never cuts into a running one.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> cnt_ff == '0)
      else $error("divider started while busy");

   // The partial remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && dsr_ff != '0) |-> rem_ff < dsr_ff)
      else $error("divider remainder out of range");

endmodule

/* rtl/buzzer_melody_note_player.sv */
// Tick, pause and abort requests queue their status as they are accepted.
// A note load runs five divisions in turn on the one-bit-per-cycle serial divider; a zero divider
// or a rest is shorter. No request is taken while a load is computed.
// Throughput: one tick, pause or abort per cycle while the status queue has room.
// Reset is synchronous: the player goes idle, the tempo returns to 120 bpm, the status queue
// empties and the stored note length clears to zero.
module buzzer_melody_note_player #(
   parameter int COUNT_WIDTH = bmnp_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bmnp_req_if.sink    req_bus,
   bmnp_rsp_if.source  rsp_bus,
   bmnp_csr_if.sink    csr_bus
);
   import bmnp_pkg::*;

   localparam int DVD_W     = COUNT_WIDTH + 5;
   localparam int DIV_CNT_W = $clog2(DVD_W + 1);
   localparam int EXT_W     = (LEN_PROD_W > COUNT_WIDTH) ? LEN_PROD_W : COUNT_WIDTH;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_TONE   = 5'b00010,
      PH_GAP    = 5'b00100,
      PH_REST   = 5'b01000,
      PH_PAUSED = 5'b10000
   } phase_type;

   typedef enum logic [8:0] {
      SQ_IDLE   = 9'b000000001,
      SQ_TEMPO  = 9'b000000010,
      SQ_MAG    = 9'b000000100,
      SQ_LEN    = 9'b000001000,
      SQ_BRANCH = 9'b000010000,
      SQ_PERIOD = 9'b000100000,
      SQ_SETUP  = 9'b001000000,
      SQ_COUNT  = 9'b010000000,
      SQ_GAPDIV = 9'b100000000
   } seq_type;

   typedef struct packed {
      logic               level;
      logic [PHASE_W-1:0] phase;
   } rsp_entry_type;

   function automatic logic [PHASE_W-1:0] phase_code(phase_type p);
      case (p)
         PH_TONE:   phase_code = PHASE_CODE_TONE;
         PH_GAP:    phase_code = PHASE_CODE_GAP;
         PH_REST:   phase_code = PHASE_CODE_REST;
         PH_PAUSED: phase_code = PHASE_CODE_PAUSED;
         default:   phase_code = PHASE_CODE_IDLE;
      endcase
   endfunction

   // Player state.
   phase_type              phase_ff, phase_in;
   logic                   level_ff, level_in;
   logic [HALF_W-1:0]      hp_ff, hp_in;
   logic [HALF_W-1:0]      hc_ff, hc_in;
   logic [COUNT_WIDTH-1:0] pl_ff, pl_in;
   logic [COUNT_WIDTH-1:0] s_ff, s_in;
   logic [COUNT_WIDTH-1:0] last_len_ff, last_len_in;
   logic                   pause_ff, pause_in;
   logic [TEMPO_W-1:0]     tempo_ff, tempo_in;

   // Note set-up sequencer and its work registers.
   seq_type                sq_ff, sq_in;
   logic                   commit_ff, commit_in;
   logic [PITCH_W-1:0]     pitch_ff, pitch_in;
   logic [NDIV_W-1:0]      mag_ff, mag_in;
   logic                   dotted_ff, dotted_in;
   logic [MS_W-1:0]        q2_ff, q2_in;
   logic [COUNT_WIDTH-1:0] len_ff, len_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;

   // Status queue of two entries.
   rsp_entry_type          slot0_ff, slot0_in;
   rsp_entry_type          slot1_ff, slot1_in;
   logic [1:0]             count_ff, count_in;

   // Divider connection.
   logic                   div_start;
   logic [DIV_CNT_W-1:0]   div_nbits;
   logic [DVD_W-1:0]       div_dvd;
   logic [DSR_W-1:0]       div_dsr;
   div_stat_type           div_stat;
   logic [DVD_W-1:0]       div_q;

   // Helpers.
   logic                   busy;
   logic                   req_take;
   logic                   load_start;
   logic                   push;
   logic                   pop;
   rsp_entry_type          push_entry;
   logic                   start_note;
   logic                   idle_go;
   logic                   sil_go;
   phase_type              sil_phase;
   logic [HALF_W-1:0]      hc_dec;
   logic [COUNT_WIDTH-1:0] pl_dec;
   logic [COUNT_WIDTH-1:0] s_dec;
   logic [TEMPO_W-1:0]     tempo_eff;
   logic [NDIV_W-1:0]      div_mag;
   logic [MULT_W-1:0]      len_mult;
   logic [LEN_PROD_W-1:0]  len_prod;
   logic [EXT_W-1:0]       len_prod_ext;
   logic [COUNT_WIDTH-1:0] len_sat;
   logic [COUNT_WIDTH-1:0] pl_sat;
   logic [DSR_W-1:0]       ten_period;
   logic [DVD_W-1:0]       count_dvd;

   bmnp_serial_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .nbits     (div_nbits),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .stat      (div_stat),
      .quotient  (div_q)
   );

   // Handshakes.
   assign busy       = (sq_ff != SQ_IDLE) || commit_ff;
   assign req_bus.ready = !busy && (count_ff != 2'd2);
   assign req_take   = req_bus.valid && req_bus.ready;
   assign load_start = req_take && (req_bus.operation == OP_LOAD) && (phase_ff == PH_IDLE);
   assign csr_bus.ready = 1'b1;
   assign tempo_in   = (csr_bus.valid && csr_bus.ready) ? csr_bus.tempo_bpm : tempo_ff;

   // Saturating decrements used by a tick.
   assign hc_dec = (hc_ff != '0) ? hc_ff - HALF_W'(1) : '0;
   assign pl_dec = (pl_ff != '0) ? pl_ff - COUNT_WIDTH'(1) : '0;
   assign s_dec  = (s_ff != '0) ? s_ff - COUNT_WIDTH'(1) : '0;

   // Operand shaping for the set-up steps.
   assign tempo_eff    = (tempo_ff == '0) ? TEMPO_W'(1) : tempo_ff;
   assign div_mag      = req_bus.note_divider[NDIV_W-1] ?
                         (NDIV_W'(0) - req_bus.note_divider) : req_bus.note_divider;
   assign len_mult     = dotted_ff ? LEN_MULT_DOTTED : LEN_MULT_PLAIN;
   assign len_prod     = LEN_PROD_W'(q2_ff) * LEN_PROD_W'(len_mult);
   assign len_prod_ext = EXT_W'(len_prod);
   assign len_sat      = (len_prod_ext > EXT_W'({COUNT_WIDTH{1'b1}})) ?
                         {COUNT_WIDTH{1'b1}} : len_prod_ext[COUNT_WIDTH-1:0];
   assign pl_sat       = (div_q[DVD_W-1:COUNT_WIDTH] != '0) ?
                         {COUNT_WIDTH{1'b1}} : div_q[COUNT_WIDTH-1:0];
   assign ten_period   = DSR_W'({period_ff, 3'b000}) + DSR_W'({period_ff, 1'b0});
   // Rounding up: (9 * length + 10 * period - 1) / (10 * period).
   assign count_dvd    = DVD_W'({len_ff, 3'b000}) + DVD_W'(len_ff) + DVD_W'(ten_period)
                         - DVD_W'(1);

   // Player and sequencer next state.
   always_comb begin
      phase_in    = phase_ff;
      level_in    = level_ff;
      hp_in       = hp_ff;
      hc_in       = hc_ff;
      pl_in       = pl_ff;
      s_in        = s_ff;
      last_len_in = last_len_ff;
      pause_in    = pause_ff;
      sq_in       = sq_ff;
      commit_in   = 1'b0;
      pitch_in    = pitch_ff;
      mag_in      = mag_ff;
      dotted_in   = dotted_ff;
      q2_in       = q2_ff;
      len_in      = len_ff;
      period_in   = period_ff;
      div_start   = 1'b0;
      div_nbits   = '0;
      div_dvd     = '0;
      div_dsr     = '0;
      start_note  = 1'b0;
      idle_go     = 1'b0;
      sil_go      = 1'b0;
      sil_phase   = PH_GAP;

      // Requests from the input channel.
      if (req_take) begin
         case (req_bus.operation)
            OP_TICK: begin
               case (phase_ff)
                  PH_TONE: begin
                     hc_in = hc_dec;
                     if (hc_dec == '0) begin
                        if (level_ff) begin
                           level_in = 1'b0;
                           hc_in    = hp_ff;
                        end else begin
                           pl_in = pl_dec;
                           if (pl_dec == '0) begin
                              sil_go    = 1'b1;
                              sil_phase = PH_GAP;
                           end else begin
                              level_in = 1'b1;
                              hc_in    = hp_ff;
                           end
                        end
                     end
                  end
                  PH_GAP, PH_REST: begin
                     s_in = s_dec;
                     if (s_dec == '0) begin
                        idle_go = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            OP_LOAD: begin
               if (phase_ff == PH_IDLE) begin
                  pitch_in  = req_bus.pitch_hz;
                  mag_in    = div_mag;
                  dotted_in = req_bus.note_divider[NDIV_W-1];
                  if (req_bus.note_divider == '0) begin
                     // Zero divider: keep the previous length.
                     len_in = last_len_ff;
                     sq_in  = SQ_BRANCH;
                  end else begin
                     div_start = 1'b1;
                     div_nbits = DIV_CNT_W'(MS_W);
                     div_dvd   = {WHOLE_BASE_MS, {(DVD_W-MS_W){1'b0}}};
                     div_dsr   = DSR_W'(tempo_eff);
                     sq_in     = SQ_TEMPO;
                  end
               end
            end
            OP_PAUSE: begin
               if (phase_ff == PH_PAUSED) begin
                  start_note = 1'b1;
               end else begin
                  pause_in = 1'b1;
               end
            end
            default: begin
               if (phase_ff != PH_IDLE) begin
                  idle_go = 1'b1;
               end
            end
         endcase
      end

      // Note set-up steps.
      case (sq_ff)
         SQ_TEMPO: begin
            if (div_stat.done) begin
               div_start = 1'b1;
               div_nbits = DIV_CNT_W'(MS_W);
               div_dvd   = {div_q[MS_W-1:0], {(DVD_W-MS_W){1'b0}}};
               div_dsr   = DSR_W'(mag_ff);
               sq_in     = SQ_MAG;
            end
         end
         SQ_MAG: begin
            if (div_stat.done) begin
               q2_in = div_q[MS_W-1:0];
               sq_in = SQ_LEN;
            end
         end
         SQ_LEN: begin
            len_in      = len_sat;
            last_len_in = len_sat;
            sq_in       = SQ_BRANCH;
         end
         SQ_BRANCH: begin
            if (pitch_ff == '0) begin
               // A rest is silent for the whole length.
               hp_in     = '0;
               pl_in     = '0;
               s_in      = len_ff;
               sq_in     = SQ_IDLE;
               commit_in = 1'b1;
            end else begin
               div_start = 1'b1;
               div_nbits = DIV_CNT_W'(PERIOD_W);
               div_dvd   = {US_PER_S, {(DVD_W-PERIOD_W){1'b0}}};
               div_dsr   = DSR_W'(pitch_ff);
               sq_in     = SQ_PERIOD;
            end
         end
         SQ_PERIOD: begin
            if (div_stat.done) begin
               period_in = div_q[PERIOD_W-1:0];
               hp_in     = div_q[PERIOD_W-1:1];
               sq_in     = SQ_SETUP;
            end
         end
         SQ_SETUP: begin
            div_start = 1'b1;
            div_nbits = DIV_CNT_W'(DVD_W);
            div_dvd   = count_dvd;
            div_dsr   = ten_period;
            sq_in     = SQ_COUNT;
         end
         SQ_COUNT: begin
            if (div_stat.done) begin
               pl_in     = pl_sat;
               div_start = 1'b1;
               div_nbits = DIV_CNT_W'(COUNT_WIDTH);
               div_dvd   = {len_ff, {(DVD_W-COUNT_WIDTH){1'b0}}};
               div_dsr   = GAP_DIVISOR;
               sq_in     = SQ_GAPDIV;
            end
         end
         SQ_GAPDIV: begin
            if (div_stat.done) begin
               s_in      = div_q[COUNT_WIDTH-1:0];
               sq_in     = SQ_IDLE;
               commit_in = 1'b1;
            end
         end
         default: ;
      endcase

      // The prepared note either waits for a pause release or starts now.
      if (commit_ff) begin
         if (pause_ff) begin
            pause_in = 1'b0;
            phase_in = PH_PAUSED;
            level_in = 1'b0;
            hc_in    = '0;
         end else begin
            start_note = 1'b1;
         end
      end

      // Start of a note from its prepared counts.
      if (start_note) begin
         if (hp_ff == '0) begin
            sil_go    = 1'b1;
            sil_phase = PH_REST;
         end else if (pl_ff == '0) begin
            sil_go    = 1'b1;
            sil_phase = PH_GAP;
         end else begin
            phase_in = PH_TONE;
            level_in = 1'b1;
            hc_in    = hp_ff;
         end
      end

      // Entering silence skips straight to idle when there is none.
      if (sil_go) begin
         level_in = 1'b0;
         hc_in    = '0;
         if (s_ff == '0) begin
            idle_go = 1'b1;
         end else begin
            phase_in = sil_phase;
         end
      end

      if (idle_go) begin
         phase_in = PH_IDLE;
         level_in = 1'b0;
         hc_in    = '0;
         pl_in    = '0;
         s_in     = '0;
      end
   end

   // Status queue: each request transfers the state after it.
   assign push             = (req_take && !load_start) || commit_ff;
   assign pop              = rsp_bus.valid && rsp_bus.ready;
   assign push_entry.level = level_in;
   assign push_entry.phase = phase_code(phase_in);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_entry;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_entry;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_entry;
         end else begin
            slot1_in = push_entry;
         end
         count_in = count_ff + 2'd1;
      end
   end

   assign rsp_bus.valid           = (count_ff != 2'd0);
   assign rsp_bus.buzzer_level    = slot0_ff.level;
   assign rsp_bus.indicator_led_n = ~slot0_ff.level;
   assign rsp_bus.player_phase    = slot0_ff.phase;
   assign rsp_bus.ready_for_note  = (slot0_ff.phase == PHASE_CODE_IDLE);

   // State registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         level_ff    <= 1'b0;
         hp_ff       <= '0;
         hc_ff       <= '0;
         pl_ff       <= '0;
         s_ff        <= '0;
         last_len_ff <= '0;
         pause_ff    <= 1'b0;
         tempo_ff    <= TEMPO_RESET;
         sq_ff       <= SQ_IDLE;
         commit_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         level_ff    <= level_in;
         hp_ff       <= hp_in;
         hc_ff       <= hc_in;
         pl_ff       <= pl_in;
         s_ff        <= s_in;
         last_len_ff <= last_len_in;
         pause_ff    <= pause_in;
         tempo_ff    <= tempo_in;
         sq_ff       <= sq_in;
         commit_ff   <= commit_in;
         count_ff    <= count_in;
      end
   end

   // Work and payload registers.
   always_ff @(posedge clock) begin
      pitch_ff  <= pitch_in;
      mag_ff    <= mag_in;
      dotted_ff <= dotted_in;
      q2_ff     <= q2_in;
      len_ff    <= len_in;
      period_ff <= period_in;
      slot0_ff  <= slot0_in;
      slot1_ff  <= slot1_in;
   end

   // The queue never takes a push it has no room for.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> count_ff != 2'd2)
      else $error("status queue overflow");

   // A prepared note always finds a free queue entry.
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      commit_ff |-> count_ff != 2'd2)
      else $error("note commit without queue room");

   // Requests are taken only while the divider rests.
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_stat.busy)
      else $error("request accepted during a division");

   // The drive is high only while a tone sounds, and a tone has a half period.
   a_level_tone: assert property (@(posedge clock) disable iff (reset)
      level_ff |-> (phase_ff == PH_TONE && hp_ff != '0))
      else $error("buzzer high outside a tone");

endmodule

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bmnp_pkg::*;

   // Arithmetic constants of the note set-up, kept at 64 bits.
   localparam longint unsigned WHOLE_NOTE_MS = 240000;
   localparam longint unsigned US_PER_SECOND = 1000000;
   localparam longint unsigned PLAIN_SCALE   = 1000;
   localparam longint unsigned DOTTED_SCALE  = 1500;
   localparam longint unsigned COUNT_LIMIT   = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;

   // Cycles that a note load may still take after the last status transfer.
   localparam int LOAD_SETTLE = 2 * COUNT_WIDTH_DEF + 130;
   localparam int TIMEOUT_NS  = 8_000_000;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PITCH_W-1:0] pitch;
      logic [NDIV_W-1:0]  ndiv;
   } note_req_type;

   typedef struct packed {
      logic               level;
      logic               led_n;
      logic [PHASE_W-1:0] phase;
      logic               idle;
   } player_status_type;

   logic clock;
   logic reset;

   bmnp_req_if req_bus ();
   bmnp_rsp_if rsp_bus ();
   bmnp_csr_if csr_bus ();

   buzzer_melody_note_player uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Requests waiting to be offered and status words waiting to be seen.
   note_req_type      note_backlog[$];
   player_status_type status_due[$];

   int mismatches = 0;
   int queued_count = 0;
   int accepted_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int hold_left = 0;
   int next_hold_at = 600;
   int stall_mode = 0;
   int mode_left = 0;

   // Predicted player state.
   logic [TEMPO_W-1:0] pl_tempo;
   logic [PHASE_W-1:0] pl_phase;
   logic               pl_level;
   logic [HALF_W-1:0]  pl_half;
   logic [63:0]        pl_half_count;
   logic [63:0]        pl_periods;
   logic [63:0]        pl_silence;
   logic [63:0]        pl_last_len;
   logic               pl_pause_pending;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [63:0] clip_count(input logic [63:0] v);
      return (v > COUNT_LIMIT) ? COUNT_LIMIT : v;
   endfunction

   task automatic player_halt();
      pl_phase = PHASE_CODE_IDLE;
      pl_level = 1'b0;
      pl_half_count = '0;
      pl_periods = '0;
      pl_silence = '0;
   endtask

   task automatic player_reset();
      pl_half = '0;
      pl_last_len = '0;
      pl_pause_pending = 1'b0;
      player_halt();
   endtask

   // Drops to silence, or straight to idle when no silence is left.
   task automatic fall_silent(input logic [PHASE_W-1:0] next_phase);
      pl_level = 1'b0;
      pl_half_count = '0;
      if (pl_silence == '0) begin
         player_halt();
      end else begin
         pl_phase = next_phase;
      end
   endtask

   task automatic sound_note();
      if (pl_half == '0) begin
         fall_silent(PHASE_CODE_REST);
      end else if (pl_periods == '0) begin
         fall_silent(PHASE_CODE_GAP);
      end else begin
         pl_phase = PHASE_CODE_TONE;
         pl_level = 1'b1;
         pl_half_count = pl_half;
      end
   endtask

   // Works out note length, half period, period count and gap for a load.
   task automatic prepare_note(input logic [PITCH_W-1:0] pitch, input logic [NDIV_W-1:0] ndiv);
      logic [63:0] bpm;
      logic [63:0] span_us;
      logic [63:0] fraction;
      logic [63:0] period_us;
      bpm = (pl_tempo == '0) ? 64'd1 : 64'(pl_tempo);
      if (ndiv == '0) begin
         span_us = pl_last_len;
      end else begin
         fraction = ndiv[NDIV_W-1] ? (64'd1 << NDIV_W) - 64'(ndiv) : 64'(ndiv);
         span_us = clip_count((WHOLE_NOTE_MS / bpm / fraction) *
                              (ndiv[NDIV_W-1] ? DOTTED_SCALE : PLAIN_SCALE));
         pl_last_len = span_us;
      end
      if (pitch == '0) begin
         pl_half = '0;
         pl_periods = '0;
         pl_silence = span_us;
      end else begin
         period_us = US_PER_SECOND / 64'(pitch);
         pl_half = period_us[HALF_W:1];
         pl_periods = clip_count((64'd9 * span_us + 64'd10 * period_us - 64'd1) /
                                 (64'd10 * period_us));
         pl_silence = span_us / 64'd10;
      end
      if (pl_pause_pending) begin
         pl_pause_pending = 1'b0;
         pl_phase = PHASE_CODE_PAUSED;
         pl_level = 1'b0;
         pl_half_count = '0;
      end else begin
         sound_note();
      end
   endtask

   // One microsecond of playback.
   task automatic advance_microsecond();
      if (pl_phase == PHASE_CODE_TONE) begin
         if (pl_half_count != '0) pl_half_count = pl_half_count - 64'd1;
         if (pl_half_count == '0) begin
            if (pl_level) begin
               pl_level = 1'b0;
               pl_half_count = pl_half;
            end else begin
               if (pl_periods != '0) pl_periods = pl_periods - 64'd1;
               if (pl_periods == '0) begin
                  fall_silent(PHASE_CODE_GAP);
               end else begin
                  pl_level = 1'b1;
                  pl_half_count = pl_half;
               end
            end
         end
      end else if (pl_phase == PHASE_CODE_GAP || pl_phase == PHASE_CODE_REST) begin
         if (pl_silence != '0) pl_silence = pl_silence - 64'd1;
         if (pl_silence == '0) player_halt();
      end
   endtask

   // Applies one accepted request and records the status it must produce.
   task automatic apply_request(input note_req_type r);
      case (r.op)
         OP_TICK: advance_microsecond();
         OP_LOAD: begin
            if (pl_phase == PHASE_CODE_IDLE) prepare_note(r.pitch, r.ndiv);
         end
         OP_PAUSE: begin
            if (pl_phase == PHASE_CODE_PAUSED) sound_note();
            else pl_pause_pending = 1'b1;
         end
         default: begin
            if (pl_phase != PHASE_CODE_IDLE) player_halt();
         end
      endcase
      status_due.push_back(player_status_type'{level: pl_level, led_n: ~pl_level,
                                               phase: pl_phase,
                                               idle: (pl_phase == PHASE_CODE_IDLE)});
   endtask

   // Request driver: offers the backlog in bursts with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.operation    <= OP_TICK;
         req_bus.pitch_hz     <= '0;
         req_bus.note_divider <= '0;
         player_reset();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_request(note_backlog.pop_front());
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || note_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid        <= 1'b1;
               req_bus.operation    <= note_backlog[0].op;
               req_bus.pitch_hz     <= note_backlog[0].pitch;
               req_bus.note_divider <= note_backlog[0].ndiv;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Long receiver hold-off, started every few thousand accepted requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         next_hold_at <= 600;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_count >= next_hold_at) begin
         hold_left <= 400;
         next_hold_at <= next_hold_at + 4000;
      end
   end

   // Status receiver: switches between always ready, half ready and mostly stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         rsp_bus.ready <= (hold_left == 0) &&
                          (stall_mode == 0 ||
                           (stall_mode == 1 && $urandom_range(0, 1) == 1) ||
                           (stall_mode == 2 && $urandom_range(0, 3) == 0));
      end
   end

   // Status monitor: each transfer is checked against the oldest prediction.
   always @(posedge clock) begin : status_monitor
      player_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_due.size() == 0) begin
            report_mismatch("status transfer with no request outstanding");
         end else begin
            want = status_due.pop_front();
            if (rsp_bus.buzzer_level !== want.level)
               report_mismatch($sformatf("buzzer_level got %b expected %b",
                                         rsp_bus.buzzer_level, want.level));
            if (rsp_bus.indicator_led_n !== want.led_n)
               report_mismatch($sformatf("indicator_led_n got %b expected %b",
                                         rsp_bus.indicator_led_n, want.led_n));
            if (rsp_bus.player_phase !== want.phase)
               report_mismatch($sformatf("player_phase got %0d expected %0d",
                                         rsp_bus.player_phase, want.phase));
            if (rsp_bus.ready_for_note !== want.idle)
               report_mismatch($sformatf("ready_for_note got %b expected %b",
                                         rsp_bus.ready_for_note, want.idle));
         end
      end
   end

   task automatic queue_request(input logic [OP_W-1:0] op, input int pitch, input int ndiv);
      note_req_type r;
      r.op = op;
      r.pitch = pitch[PITCH_W-1:0];
      r.ndiv = ndiv[NDIV_W-1:0];
      note_backlog.push_back(r);
      queued_count++;
   endtask

   function automatic int pick_pitch();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 8191);
         2: return 8191;
         default: return $urandom_range(4096, 8191);
      endcase
   endfunction

   function automatic int pick_divider();
      if ($urandom_range(0, 9) == 0) return 0;
      return int'($urandom_range(0, 128)) - 64;
   endfunction

   task automatic queue_ticks(input int n);
      for (int k = 0; k < n; k++) queue_request(OP_TICK, pick_pitch(), pick_divider());
   endtask

   // One note from load to abort, with a little noise mixed into the ticks.
   task automatic play_episode();
      int ticks;
      logic held;
      held = ($urandom_range(0, 4) == 0);
      ticks = $urandom_range(0, 150);
      if (held) queue_request(OP_PAUSE, pick_pitch(), pick_divider());
      queue_request(OP_LOAD, pick_pitch(), pick_divider());
      if (held) begin
         queue_ticks($urandom_range(0, 3));
         queue_request(($urandom_range(0, 3) == 0) ? OP_ABORT : OP_PAUSE,
                       pick_pitch(), pick_divider());
      end
      for (int k = 0; k < ticks; k++) begin
         case ($urandom_range(0, 39))
            0: queue_request(OP_LOAD, pick_pitch(), pick_divider());
            1: queue_request(OP_PAUSE, pick_pitch(), pick_divider());
            2: queue_request(OP_ABORT, pick_pitch(), pick_divider());
            default: queue_request(OP_TICK, pick_pitch(), pick_divider());
         endcase
      end
      if ($urandom_range(0, 7) != 0) queue_request(OP_ABORT, pick_pitch(), pick_divider());
   endtask

   // Lets a short note run through tone, gap and back to idle.
   task automatic play_to_end(input int pitch, input int ndiv, input int ticks);
      queue_request(OP_LOAD, pitch, ndiv);
      queue_ticks(ticks);
      queue_request(OP_ABORT, pick_pitch(), pick_divider());
   endtask

   task automatic random_phase(input int quota);
      int start_count;
      start_count = queued_count;
      while (queued_count - start_count < quota) play_episode();
   endtask

   // Waits until every request is checked and any load has had time to finish.
   task automatic settle();
      do @(negedge clock); while (note_backlog.size() != 0 || status_due.size() != 0);
      repeat (LOAD_SETTLE) @(negedge clock);
   endtask

   task automatic write_tempo(input logic [TEMPO_W-1:0] bpm);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.tempo_bpm <= bpm;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      pl_tempo = bpm;
   endtask

   initial begin : stimulus
      pl_tempo = TEMPO_RESET;
      csr_bus.valid = 1'b0;
      csr_bus.tempo_bpm = TEMPO_RESET;
      do @(negedge clock); while (reset);

      // Directed checks at tempo zero, which counts as one beat per minute.
      write_tempo(0);
      queue_request(OP_LOAD, 440, 0);     // zero divider before any note: zero length
      queue_request(OP_LOAD, 0, 0);       // rest of zero length
      queue_request(OP_ABORT, 8191, -64); // abort while idle
      queue_request(OP_TICK, 0, 64);      // tick while idle
      queue_request(OP_LOAD, 8191, 64);
      queue_request(OP_LOAD, 100, 1);     // load while busy is ignored
      queue_ticks(2);
      queue_request(OP_PAUSE, 0, 0);      // pause while playing arms the next load
      queue_request(OP_ABORT, 0, 0);      // abort keeps the pending pause
      queue_request(OP_LOAD, 1, -64);     // held, lowest pitch, dotted
      queue_request(OP_TICK, 0, 0);       // tick while paused
      queue_request(OP_LOAD, 2000, 2);    // load while paused is ignored
      queue_request(OP_PAUSE, 0, 0);      // second pause starts the held note
      queue_request(OP_TICK, 0, 0);
      queue_request(OP_ABORT, 0, 0);
      queue_request(OP_PAUSE, 0, 0);
      queue_request(OP_LOAD, 0, -1);      // held rest
      queue_request(OP_ABORT, 0, 0);      // abort while paused
      queue_request(OP_LOAD, 0, 1);
      queue_request(OP_TICK, 0, 0);
      queue_request(OP_ABORT, 0, 0);
      queue_request(OP_LOAD, 4096, 0);    // reuse of the previous length
      queue_request(OP_TICK, 0, 0);
      queue_request(OP_ABORT, 0, 0);
      settle();

      // Fastest tempo with the finest divider: notes short enough to play out completely.
      write_tempo(1023);
      play_to_end(8191, 127, 1100);
      play_to_end(0, 127, 1020);
      random_phase(40);
      settle();

      write_tempo(1);
      random_phase(40);
      settle();

      write_tempo(TEMPO_RESET);
      random_phase(40);
      settle();

      write_tempo($urandom_range(2, 1022));
      random_phase(40);
      settle();

      write_tempo(1023);
      random_phase(40);
      settle();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
